// File: sv/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants of the colour-keyed sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package scb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 128;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int FB_ADDR_W  = 14;
    localparam int POS_W      = 18;

    localparam logic [15:0] KEY_COLOR_RESET = 16'hE01F;

    typedef enum logic [2:0] {
        REG_DEST_X       = 3'd0,
        REG_DEST_Y       = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_KEY_COLOR    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  image_width;
        logic [7:0]  image_height;
        logic [15:0] key_color;
    } scb_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] pixel;
        logic [7:0]  column;
        logic [7:0]  row;
        logic        last;
    } scb_stage_t;

endpackage

`default_nettype wire

// File: sv/scb_regs.sv
// ----------------------------------------------------------------------------
// scb_regs
// APB register file: position, geometry and key colour.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_regs
    import scb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output scb_cfg_t                   cfg
);

    scb_cfg_t   cfg_reg;
    reg_index_t index;
    logic       write_en;

    assign index    = reg_index_t'(paddr[4:2]);
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x       <= '0;
            cfg_reg.dest_y       <= '0;
            cfg_reg.image_width  <= 8'd1;
            cfg_reg.image_height <= 8'd1;
            cfg_reg.key_color    <= KEY_COLOR_RESET;
        end else if (write_en) begin
            case (index)
                REG_DEST_X:       cfg_reg.dest_x       <= pwdata[15:0];
                REG_DEST_Y:       cfg_reg.dest_y       <= pwdata[15:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[7:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[7:0];
                REG_KEY_COLOR:    cfg_reg.key_color    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_DEST_X:       prdata = {16'd0, cfg_reg.dest_x};
            REG_DEST_Y:       prdata = {16'd0, cfg_reg.dest_y};
            REG_IMAGE_WIDTH:  prdata = {24'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {24'd0, cfg_reg.image_height};
            REG_KEY_COLOR:    prdata = {16'd0, cfg_reg.key_color};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/scb_fetch.sv
// ----------------------------------------------------------------------------
// scb_fetch
// Input stage: registers each word with its stored column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_fetch
    import scb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire scb_cfg_t    cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_pixel_word,
    input  wire logic        advance,
    output scb_stage_t       stage
);

    scb_stage_t stage_reg;
    logic [7:0] column_count_reg, column_count_next;
    logic [7:0] row_count_reg, row_count_next;
    logic [8:0] stored_width;
    logic       row_end;
    logic       last_row;
    logic       accept;

    assign s_ready = !stage_reg.valid || advance;
    assign accept  = s_valid && s_ready;
    assign stage   = stage_reg;

    // stored rows are padded to an even width
    assign stored_width = ({1'b0, cfg.image_width} + 9'd1) & 9'h1FE;
    assign row_end      = ({1'b0, column_count_reg} + 9'd1) >= stored_width;
    assign last_row     = ({1'b0, row_count_reg} + 9'd1) >= {1'b0, cfg.image_height};

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept) begin
            if (row_end) begin
                column_count_next = '0;
                row_count_next    = last_row ? 8'd0 : row_count_reg + 8'd1;
            end else begin
                column_count_next = column_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            stage_reg.valid  <= 1'b0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (s_ready) begin
                stage_reg.valid <= s_valid;
            end
        end
        if (accept) begin
            stage_reg.pixel  <= s_pixel_word;
            stage_reg.column <= column_count_reg;
            stage_reg.row    <= row_count_reg;
            stage_reg.last   <= row_end && last_row;
        end
    end

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !row_end |=> column_count_reg == $past(column_count_reg) + 8'd1)
        else $error("column count did not step");

    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && row_end && !last_row |=>
            column_count_reg == 8'd0 && row_count_reg == $past(row_count_reg) + 8'd1)
        else $error("row count did not step at row end");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg.valid && !advance |=> stage_reg.valid && $stable(stage_reg.pixel))
        else $error("stalled stage lost its word");

endmodule

`default_nettype wire

// File: sv/scb_map.sv
// ----------------------------------------------------------------------------
// scb_map
// Result stage: screen mapping, clipping, colour key and address.
// ----------------------------------------------------------------------------
`default_nettype none

module scb_map
    import scb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire scb_cfg_t             cfg,
    input  wire scb_stage_t           stage,
    output logic                      advance,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_write_enable,
    output logic      [FB_ADDR_W-1:0] m_fb_address,
    output logic      [15:0]          m_fb_color,
    output logic                      m_last_word
);

    localparam logic signed [POS_W-1:0] SW_POS  = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] SH_POS  = POS_W'(SCREEN_HEIGHT);
    localparam logic [FB_ADDR_W-1:0]    SW_ADDR = FB_ADDR_W'(SCREEN_WIDTH);

    logic                       m_valid_reg;
    logic                       write_enable_reg, write_enable_next;
    logic [FB_ADDR_W-1:0]       fb_address_reg, fb_address_next;
    logic [15:0]                fb_color_reg, fb_color_next;
    logic                       last_word_reg;
    logic signed [POS_W-1:0]    sx, sy;
    logic [FB_ADDR_W-1:0]       addr;
    logic                       visible;

    assign advance = !m_valid_reg || m_ready;

    assign sx = $signed({{2{cfg.dest_x[15]}}, cfg.dest_x})
              + $signed({10'd0, stage.column});
    assign sy = $signed({{2{cfg.dest_y[15]}}, cfg.dest_y})
              + $signed({10'd0, cfg.image_height})
              - $signed(18'd1)
              - $signed({10'd0, stage.row});

    assign visible = (stage.column < cfg.image_width)
                  && !sx[POS_W-1] && (sx < SW_POS)
                  && !sy[POS_W-1] && (sy < SH_POS);

    // only the low address bits are kept
    assign addr = sy[FB_ADDR_W-1:0] * SW_ADDR + sx[FB_ADDR_W-1:0];

    always_comb begin
        write_enable_next = visible && (stage.pixel != cfg.key_color);
        fb_address_next   = write_enable_next ? addr : '0;
        fb_color_next     = write_enable_next ? stage.pixel : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stage.valid;
        end
        if (advance && stage.valid) begin
            write_enable_reg <= write_enable_next;
            fb_address_reg   <= fb_address_next;
            fb_color_reg     <= fb_color_next;
            last_word_reg    <= stage.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = write_enable_reg;
    assign m_fb_address   = fb_address_reg;
    assign m_fb_color     = fb_color_reg;
    assign m_last_word    = last_word_reg;

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !write_enable_reg |-> fb_address_reg == '0 && fb_color_reg == '0)
        else $error("suppressed write carries data");

    a_key_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && write_enable_reg |-> fb_color_reg != cfg.key_color)
        else $error("key colour written");

endmodule

`default_nettype wire

// File: sv/sprite_clip_blit_top.sv
// ----------------------------------------------------------------------------
// sprite_clip_blit_top
// Colour-keyed sprite blitter with screen clipping.
// ----------------------------------------------------------------------------
// Pixel words of a bitmap arrive in storage order (rows bottom-up, each row
// padded to an even width); each transaction yields one framebuffer write
// result, with write_enable low for pad columns, off-screen pixels and the
// key colour. One word is taken every clock while m_ready does not stall the
// output; a word's result is registered first in the input register and then
// in the result register. The column and row counters wrap after the last
// stored word, flagged by last_word. Registers must be written over APB only
// while no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_clip_blit_top
    import scb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [15:0]           s_pixel_word,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_write_enable,
    output logic      [FB_ADDR_W-1:0]  m_fb_address,
    output logic      [15:0]           m_fb_color,
    output logic                       m_last_word
);

    scb_cfg_t   cfg;
    scb_stage_t stage;
    logic       advance;

    scb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scb_fetch u_fetch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_word (s_pixel_word),
        .advance      (advance),
        .stage        (stage)
    );

    scb_map #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_map (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .stage          (stage),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_fb_address   (m_fb_address),
        .m_fb_color     (m_fb_color),
        .m_last_word    (m_last_word)
    );

endmodule

`default_nettype wire
